FILE: rtl/button_debounce_double_press_unit_macros.svh
// Assertion macros for the button debounce and double-press unit.
`ifndef BUTTON_DEBOUNCE_DOUBLE_PRESS_UNIT_MACROS_SVH
`define BUTTON_DEBOUNCE_DOUBLE_PRESS_UNIT_MACROS_SVH

// Same-cycle implication, checked on rising clk_i outside reset.
`define BDDP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bddp assertion failed");

// Next-cycle implication, checked on rising clk_i outside reset.
`define BDDP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bddp assertion failed");

`endif

FILE: rtl/bddp_pkg.sv
// Shared types and constants for the button debounce and double-press unit.
`default_nettype none
package bddp_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned InDataW = 40;
  localparam int unsigned OutDataW = 8;

  localparam logic [CfgW-1:0] DebounceReset = 16'd40;
  localparam logic [CfgW-1:0] WindowReset   = 16'd350;

  // Configuration register indexes
  localparam logic REG_DEBOUNCE = 1'b0;
  localparam logic REG_WINDOW   = 1'b1;

  typedef struct packed {
    logic             alarm_active;
    logic [TimeW-1:0] now_ms;
    logic             raw_pressed;
  } in_item_t;

  typedef struct packed {
    logic debounced_pressed;
    logic toggle_alarm;
    logic stop_alarm;
  } out_item_t;

  typedef struct packed {
    logic we;
    logic idx;
    logic [CfgW-1:0] data;
  } cfg_wr_t;

endpackage
`default_nettype wire

FILE: rtl/bddp_core.sv
// Timing registers plus debounce and click state with its single-pass next-state logic.
`default_nettype none
module bddp_core
  import bddp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cfg_wr_t   cfg_i,
  input  wire logic      step_i,
  input  wire in_item_t  item_i,
  output out_item_t      result_o
);

  logic [CfgW-1:0]  debounce_q, window_q;
  logic             last_raw_q, last_raw_d;
  logic             stable_q, stable_d;
  logic             swallow_q, swallow_d;
  logic             one_click_q, one_click_d;
  logic [TimeW-1:0] last_edge_q, last_edge_d;
  logic [TimeW-1:0] first_click_q, first_click_d;

  logic [TimeW-1:0] elapsed, click_age;
  logic             settled, expired, done, stop, toggle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DebounceReset;
      window_q   <= WindowReset;
    end else if (cfg_i.we) begin
      case (cfg_i.idx)
        REG_DEBOUNCE: debounce_q <= cfg_i.data;
        REG_WINDOW:   window_q   <= cfg_i.data;
        default:      ;
      endcase
    end
  end

  always_comb begin
    last_raw_d    = item_i.raw_pressed;
    last_edge_d   = (item_i.raw_pressed != last_raw_q) ? item_i.now_ms : last_edge_q;
    elapsed       = item_i.now_ms - last_edge_d;
    settled       = elapsed >= {{(TimeW-CfgW){1'b0}}, debounce_q};
    click_age     = item_i.now_ms - first_click_q;
    expired       = click_age > {{(TimeW-CfgW){1'b0}}, window_q};
    stable_d      = stable_q;
    swallow_d     = swallow_q;
    one_click_d   = one_click_q;
    first_click_d = first_click_q;
    done          = 1'b0;
    stop          = 1'b0;
    toggle        = 1'b0;
    if (settled) begin
      if (stable_q != item_i.raw_pressed) begin
        stable_d = item_i.raw_pressed;
        if (item_i.raw_pressed) begin
          if (item_i.alarm_active) begin
            stop          = 1'b1;
            swallow_d     = 1'b1;
            one_click_d   = 1'b0;
            first_click_d = '0;
          end
          done = 1'b1;
        end else if (swallow_q) begin
          swallow_d = 1'b0;
          done      = 1'b1;
        end else if (!one_click_q || expired) begin
          one_click_d   = 1'b1;
          first_click_d = item_i.now_ms;
          done          = 1'b1;
        end else begin
          one_click_d   = 1'b0;
          first_click_d = '0;
          toggle        = 1'b1;
        end
      end
      // lone click ages out of the window while released
      if (!done && !stable_d && one_click_q && expired) begin
        one_click_d   = 1'b0;
        first_click_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q    <= 1'b0;
      stable_q      <= 1'b0;
      swallow_q     <= 1'b0;
      one_click_q   <= 1'b0;
      last_edge_q   <= '0;
      first_click_q <= '0;
    end else if (step_i) begin
      last_raw_q    <= last_raw_d;
      stable_q      <= stable_d;
      swallow_q     <= swallow_d;
      one_click_q   <= one_click_d;
      last_edge_q   <= last_edge_d;
      first_click_q <= first_click_d;
    end
  end

  assign result_o.stop_alarm        = stop;
  assign result_o.toggle_alarm      = toggle;
  assign result_o.debounced_pressed = stable_d;

endmodule
`default_nettype wire

FILE: rtl/bddp_out_reg.sv
// Result register with valid/ready handshake toward the consumer.
`default_nettype none
module bddp_out_reg
  import bddp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      load_i,
  input  wire out_item_t result_i,
  input  wire logic      ready_i,
  output logic           free_o,
  output logic           valid_o,
  output out_item_t      result_o
);

  logic      valid_q;
  out_item_t result_q;

  assign free_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule
`default_nettype wire

FILE: rtl/button_debounce_double_press_unit.sv
// An accepted item is registered, runs the state logic and lands in the result register.
// Throughput: one item per cycle while m_axis_tready does not stall the result register.
// A stalled result register holds a full input register, which then drops s_axis_tready.
// Reset (rst_ni low, async): state cleared, debounce 40 ms, double-press window 350 ms.
`default_nettype none
`include "button_debounce_double_press_unit_macros.svh"
module button_debounce_double_press_unit
  import bddp_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_idx_i,
  input  wire logic [CfgW-1:0]     cfg_data_i,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // [0] raw_pressed, [32:1] now_ms, [33] alarm_active, [39:34] unused
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [0] stop_alarm, [1] toggle_alarm, [2] debounced_pressed, [7:3] zero
  output logic [OutDataW-1:0]      m_axis_tdata
);

  logic      in_valid_q;
  in_item_t  in_item_q;
  cfg_wr_t   cfg;
  logic      out_free, advance;
  out_item_t core_result, out_result;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q <= s_axis_tdata[$bits(in_item_t)-1:0];
    end
  end

  bddp_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .step_i   (advance),
    .item_i   (in_item_q),
    .result_o (core_result)
  );

  bddp_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance),
    .result_i (core_result),
    .ready_i  (m_axis_tready),
    .free_o   (out_free),
    .valid_o  (m_axis_tvalid),
    .result_o (out_result)
  );

  assign m_axis_tdata = {{(OutDataW-$bits(out_item_t)){1'b0}}, out_result};

  `BDDP_ASSERT_NOW(a_pulses_exclusive, m_axis_tvalid, !(m_axis_tdata[0] && m_axis_tdata[1]))
  `BDDP_ASSERT_NOW(a_stop_when_pressed, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[2])
  `BDDP_ASSERT_NOW(a_toggle_when_released, m_axis_tvalid && m_axis_tdata[1], !m_axis_tdata[2])
  `BDDP_ASSERT_NEXT(a_item_lands_in_result, advance, m_axis_tvalid)

endmodule
`default_nettype wire

FILE: tb/tb_button_debounce_double_press_unit.sv
// Self-checking testbench for the button debounce and double-press unit.
`timescale 1ns / 1ps

module tb_button_debounce_double_press_unit;
  import bddp_pkg::*;

  // Directed row: sample fields, plus a hand-written result where one is obvious.
  typedef struct packed {
    logic             raw_pressed;
    logic [TimeW-1:0] now_ms;
    logic             alarm_active;
    logic             typed;
    out_item_t        want;  // {debounced_pressed, toggle_alarm, stop_alarm}
  } dir_row_t;

  localparam int NumDirRows = 26;
  localparam int NumPhases  = 6;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic                cfg_idx_i     = REG_DEBOUNCE;
  logic [CfgW-1:0]     cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  // Predictor state and its copy of the timing registers
  logic [CfgW-1:0]  pr_debounce   = DebounceReset;
  logic [CfgW-1:0]  pr_window     = WindowReset;
  logic             pr_last_raw   = 1'b0;
  logic             pr_stable     = 1'b0;
  logic             pr_swallow    = 1'b0;
  logic             pr_click_seen = 1'b0;
  logic [TimeW-1:0] pr_edge_time  = '0;
  logic [TimeW-1:0] pr_click_time = '0;

  // Random sample stream
  logic [TimeW-1:0] rnd_now   = '0;
  logic             rnd_raw   = 1'b0;
  logic             rnd_alarm = 1'b0;

  out_item_t pending_results[$];
  dir_row_t  dir_rows [NumDirRows];

  int errors         = 0;
  int n_items        = 0;
  int n_results      = 0;
  int n_toggles      = 0;
  int n_stops        = 0;
  int n_settings     = 1;
  int long_hold_req  = 0;
  int long_hold_seen = 0;
  int src_calm       = 0;
  int snk_calm       = 0;
  int snk_gap        = 0;

  button_debounce_double_press_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic out_item_t predict_button(in_item_t it);
    out_item_t        res;
    logic [TimeW-1:0] since_edge;
    logic [TimeW-1:0] since_click;
    logic             handled;
    res = '0;
    handled = 1'b0;
    if (it.raw_pressed != pr_last_raw) begin
      pr_last_raw  = it.raw_pressed;
      pr_edge_time = it.now_ms;
    end
    since_edge = it.now_ms - pr_edge_time;
    if (since_edge >= {16'd0, pr_debounce}) begin
      if (pr_stable != it.raw_pressed) begin
        pr_stable   = it.raw_pressed;
        since_click = it.now_ms - pr_click_time;
        if (pr_stable) begin
          if (it.alarm_active) begin
            res.stop_alarm = 1'b1;
            pr_swallow     = 1'b1;
            pr_click_seen  = 1'b0;
            pr_click_time  = '0;
          end
          handled = 1'b1;
        end else if (pr_swallow) begin
          pr_swallow = 1'b0;
          handled    = 1'b1;
        end else if (!pr_click_seen || since_click > {16'd0, pr_window}) begin
          pr_click_seen = 1'b1;
          pr_click_time = it.now_ms;
          handled       = 1'b1;
        end else begin
          pr_click_seen    = 1'b0;
          pr_click_time    = '0;
          res.toggle_alarm = 1'b1;
        end
      end
      // lone click times out while released
      since_click = it.now_ms - pr_click_time;
      if (!handled && !pr_stable && pr_click_seen && since_click > {16'd0, pr_window}) begin
        pr_click_seen = 1'b0;
        pr_click_time = '0;
      end
    end
    res.debounced_pressed = pr_stable;
    return res;
  endfunction

  // Mostly well-formed press/release runs; some bounce and some wild timestamps.
  function automatic in_item_t next_sample(int unsigned scale, int unsigned bounce);
    in_item_t    it;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      it.raw_pressed  = 1'($urandom_range(0, 1));
      it.now_ms       = $urandom;
      it.alarm_active = 1'($urandom_range(0, 1));
      return it;
    end
    if (r < 20) begin
      rnd_raw = ~rnd_raw;
      rnd_now = rnd_now + $urandom_range(0, bounce);
    end else begin
      if ($urandom_range(0, 3) == 0) rnd_raw = ~rnd_raw;
      rnd_now = rnd_now + $urandom_range(0, scale);
    end
    if ($urandom_range(0, 5) == 0) rnd_alarm = ~rnd_alarm;
    it.raw_pressed  = rnd_raw;
    it.now_ms       = rnd_now;
    it.alarm_active = rnd_alarm;
    return it;
  endfunction

  function automatic int src_gap();
    int unsigned r;
    if (src_calm > 0) begin
      src_calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      src_calm = $urandom_range(30, 120);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_sample(in_item_t it, logic typed, out_item_t want);
    int        gap;
    out_item_t res;
    gap = src_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW - $bits(in_item_t)){1'b0}}, it};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    res = predict_button(it);
    pending_results.push_back(typed ? want : res);
    n_items++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_timing(logic [CfgW-1:0] debounce, logic [CfgW-1:0] window);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_DEBOUNCE;
    cfg_data_i <= debounce;
    @(posedge clk_i);
    cfg_idx_i  <= REG_WINDOW;
    cfg_data_i <= window;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    pr_debounce = debounce;
    pr_window   = window;
    n_settings++;
    @(posedge clk_i);
  endtask

  task automatic run_random(int count);
    int unsigned scale;
    int unsigned bounce;
    scale  = pr_debounce / 2 + pr_window / 4 + 2;
    bounce = pr_debounce / 4 + 1;
    rnd_now = $urandom;
    repeat (count) send_sample(next_sample(scale, bounce), 1'b0, '0);
  endtask

  task automatic cmp_field(string name, logic want, logic got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0b, actual %0b", $realtime, name, want, got);
      errors++;
    end
  endtask

  // Result side: checks and random back-pressure
  always @(posedge clk_i) begin
    out_item_t want;
    out_item_t got;
    logic      next_ready;
    int unsigned r;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = out_item_t'(m_axis_tdata[$bits(out_item_t)-1:0]);
        n_results++;
        if (got.toggle_alarm) n_toggles++;
        if (got.stop_alarm) n_stops++;
        if (pending_results.size() == 0) begin
          $display("%0t: result %03b with no item pending", $realtime, got);
          errors++;
        end else begin
          want = pending_results.pop_front();
          cmp_field("stop_alarm", want.stop_alarm, got.stop_alarm);
          cmp_field("toggle_alarm", want.toggle_alarm, got.toggle_alarm);
          cmp_field("debounced_pressed", want.debounced_pressed, got.debounced_pressed);
        end
      end
      if (long_hold_seen != long_hold_req) begin
        long_hold_seen = long_hold_req;
        snk_gap = 300;
      end
      if (snk_gap > 0) begin
        snk_gap--;
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
        if (snk_calm > 0) begin
          snk_calm--;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 4) snk_calm = $urandom_range(30, 120);
          else if (r < 80) snk_gap = 0;
          else if (r < 97) snk_gap = $urandom_range(1, 3);
          else snk_gap = $urandom_range(15, 50);
        end
      end
      m_axis_tready <= next_ready;
    end
  end

  initial begin
    in_item_t        it;
    logic [CfgW-1:0] ph_debounce [NumPhases];
    logic [CfgW-1:0] ph_window   [NumPhases];
    int              ph_count    [NumPhases];

    dir_rows = '{
      '{1'b0, 32'd0,          1'b0, 1'b1, 3'b000},  // just out of reset, settling
      '{1'b1, 32'd100,        1'b0, 1'b0, 3'b000},
      '{1'b1, 32'd139,        1'b0, 1'b0, 3'b000},  // one ms short of the hold time
      '{1'b1, 32'd140,        1'b0, 1'b1, 3'b100},  // press, no alarm
      '{1'b0, 32'd200,        1'b0, 1'b0, 3'b000},
      '{1'b0, 32'd240,        1'b0, 1'b0, 3'b000},  // first click
      '{1'b1, 32'd300,        1'b0, 1'b0, 3'b000},
      '{1'b1, 32'd340,        1'b0, 1'b0, 3'b000},
      '{1'b0, 32'd350,        1'b0, 1'b0, 3'b000},
      '{1'b0, 32'd390,        1'b0, 1'b1, 3'b010},  // second release in window
      '{1'b1, 32'd1000,       1'b1, 1'b0, 3'b000},
      '{1'b1, 32'd1040,       1'b1, 1'b1, 3'b101},  // press stops the alarm
      '{1'b0, 32'd1100,       1'b1, 1'b0, 3'b000},
      '{1'b0, 32'd1140,       1'b0, 1'b1, 3'b000},  // swallowed release
      '{1'b1, 32'd2000,       1'b0, 1'b0, 3'b000},
      '{1'b1, 32'd2040,       1'b0, 1'b0, 3'b000},
      '{1'b0, 32'd2100,       1'b0, 1'b0, 3'b000},
      '{1'b0, 32'd2140,       1'b0, 1'b0, 3'b000},
      '{1'b0, 32'd2491,       1'b0, 1'b0, 3'b000},  // window just passed
      '{1'b1, 32'd2500,       1'b0, 1'b0, 3'b000},
      '{1'b1, 32'd2540,       1'b0, 1'b0, 3'b000},
      '{1'b0, 32'd2600,       1'b0, 1'b0, 3'b000},
      '{1'b0, 32'd2640,       1'b0, 1'b0, 3'b000},
      '{1'b1, 32'hFFFF_FFFF,  1'b1, 1'b0, 3'b000},  // edge at the top of time
      '{1'b1, 32'd39,         1'b1, 1'b0, 3'b000},  // hold time met across the wrap
      '{1'b1, 32'd10,         1'b0, 1'b0, 3'b000}   // timestamp going backwards
    };

    ph_debounce = '{16'd0, 16'd0,     16'hFFFF, 16'hFFFF, 16'd10,  16'd0};
    ph_window   = '{16'd0, 16'hFFFF,  16'hFFFF, 16'd0,    16'd300, 16'd0};
    ph_count    = '{70,    70,        60,       40,       120,     120};
    ph_debounce[NumPhases-1] = 16'($urandom_range(0, 80));
    ph_window[NumPhases-1]   = 16'($urandom_range(0, 600));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset timing values first
    for (int i = 0; i < NumDirRows; i++) begin
      it.raw_pressed  = dir_rows[i].raw_pressed;
      it.now_ms       = dir_rows[i].now_ms;
      it.alarm_active = dir_rows[i].alarm_active;
      send_sample(it, dir_rows[i].typed, dir_rows[i].want);
    end
    run_random(100);
    drain();

    for (int p = 0; p < NumPhases; p++) begin
      set_timing(ph_debounce[p], ph_window[p]);
      if (p == 4) long_hold_req++;  // stall the result side to fill the pipe
      run_random(ph_count[p]);
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $realtime, pending_results.size());
      errors++;
    end
    $display("Ran %0d button samples over %0d timing settings, %0d results checked.",
             n_items, n_settings, n_results);
    $display("Saw %0d double-press toggles and %0d alarm stops; %0d errors.",
             n_toggles, n_stops, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("%0t: timeout, %0d results still pending", $realtime, pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/bddp_pkg.sv
rtl/bddp_core.sv
rtl/bddp_out_reg.sv
rtl/button_debounce_double_press_unit.sv
tb/tb_button_debounce_double_press_unit.sv
